>>> src/tbpc_pkg.sv
// tbpc_pkg: types, constants and the mode wrap table for the button press controller
// no dependencies; used by the item interfaces and the core
`timescale 1ns / 1ps

package tbpc_pkg;

  localparam int unsigned MODE_COUNT = 25;

  localparam int unsigned ModeW   = 5;
  localparam int unsigned HueW    = 8;
  localparam int unsigned BrightW = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ModeTabN = 2 ** ModeW;

  localparam logic [TimeW-1:0]   LedLongMs    = 32'd2000;
  localparam logic [TimeW-1:0]   LedShortMs   = 32'd1000;
  localparam logic [HueW-1:0]    HueStep      = 8'd16;
  localparam logic [HueW-1:0]    HueHalf      = 8'd128;
  localparam logic [BrightW:0]   BrightStep   = 9'd25;
  localparam logic [BrightW:0]   BrightMod    = 9'd255;
  localparam logic [BrightW-1:0] BrightMin    = 8'd12;

  localparam logic [CfgW-1:0]    LongPressRst = 16'd3000;
  localparam logic [CfgW-1:0]    MinPressRst  = 16'd50;
  localparam logic [CfgW-1:0]    LockoutRst   = 16'd300;
  localparam logic [ModeW-1:0]   StartModeRst = 5'd0;
  localparam logic [HueW-1:0]    StartHueRst  = 8'd0;
  localparam logic [BrightW-1:0] StartBrtRst  = 8'd128;
  localparam logic               StartCliRst  = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLongPress  = 3'd0,
    CfgMinPress   = 3'd1,
    CfgLockout    = 3'd2,
    CfgStartMode  = 3'd3,
    CfgStartHue   = 3'd4,
    CfgStartBrt   = 3'd5,
    CfgStartCli   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             mode_level;
    logic             color_level;
    logic             bright_level;
  } in_item_t;

  typedef struct packed {
    logic [ModeW-1:0]   mode_value;
    logic [HueW-1:0]    primary_hue;
    logic [HueW-1:0]    secondary_hue;
    logic [BrightW-1:0] bright_value;
    logic               client_mode;
    logic               short_press_event;
    logic               long_press_event;
    logic               color_step_event;
    logic               bright_step_event;
    logic [TimeW-1:0]   mode_led_off_ms;
    logic [TimeW-1:0]   color_led_off_ms;
    logic [TimeW-1:0]   bright_led_off_ms;
  } out_item_t;

  typedef logic [ModeTabN-1:0][ModeW-1:0] mode_tab_t;

  // entry m holds (m + 1) mod MODE_COUNT
  function automatic mode_tab_t build_mode_tab();
    mode_tab_t tab;
    int unsigned cnt;
    cnt = 1;
    for (int unsigned i = 0; i < ModeTabN; i++) begin
      tab[i] = ModeW'(cnt);
      cnt = (cnt == MODE_COUNT - 1) ? 0 : cnt + 1;
    end
    return tab;
  endfunction

  localparam mode_tab_t ModeNextTab = build_mode_tab();

endpackage

>>> src/tbpc_in_if.sv
// tbpc_in_if: valid/ready channel carrying one button sample item
// depends on tbpc_pkg
`timescale 1ns / 1ps

interface tbpc_in_if;
  logic              valid;
  logic              ready;
  tbpc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/tbpc_out_if.sv
// tbpc_out_if: valid/ready channel carrying one result item
// depends on tbpc_pkg
`timescale 1ns / 1ps

interface tbpc_out_if;
  logic               valid;
  logic               ready;
  tbpc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/three_button_press_controller_core.sv
// three_button_press_controller_core: mode / colour / brightness button handling
// depends on tbpc_pkg, tbpc_in_if and tbpc_out_if
`timescale 1ns / 1ps

// channel   dir  handshake     payload
// in_i      in   valid/ready   now_ms, mode_level, color_level, bright_level
// out_o     out  valid/ready   mode, hues, brightness, client flag, events, led off times
// cfg_*     in   write enable  register index, 16-bit data
//
// an item is held in the input register, then its result sits in the output register
// one item per cycle sustained while the output is taken; the state update is a single pass
// reset clears both valid flags and loads the register reset values and state presets
// a stalled output holds its item; the input register still advances when it is taken

module three_button_press_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tbpc_in_if.sink                       in_i,
  tbpc_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [tbpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tbpc_pkg::CfgW-1:0]     cfg_data_i
);

  logic                 in_valid_q;
  tbpc_pkg::in_item_t   in_q;
  logic                 out_valid_q;
  tbpc_pkg::out_item_t  res_q, res_d;
  logic                 advance;

  logic [tbpc_pkg::CfgW-1:0]    long_q, long_d, min_q, min_d, lock_q, lock_d;
  logic [tbpc_pkg::ModeW-1:0]   smode_q, smode_d, mode_q, mode_d;
  logic [tbpc_pkg::HueW-1:0]    shue_q, shue_d, hue_q, hue_d;
  logic [tbpc_pkg::BrightW-1:0] sbrt_q, sbrt_d, brt_q, brt_d;
  logic                         scli_q, scli_d, cli_q, cli_d;
  logic                         held_q, held_d;
  logic [tbpc_pkg::TimeW-1:0]   start_q, start_d;
  logic [tbpc_pkg::TimeW-1:0]   lmode_q, lmode_d, lcol_q, lcol_d, lbrt_q, lbrt_d;
  logic [tbpc_pkg::TimeW-1:0]   led0_q, led0_d, led1_q, led1_d, led2_q, led2_d;

  logic [tbpc_pkg::TimeW-1:0]   dur, dt_mode, dt_col, dt_brt;
  logic [tbpc_pkg::TimeW-1:0]   long_x, min_x, lock_x;
  logic [tbpc_pkg::BrightW:0]   brt_sum, brt_mod;
  logic                         ev_short, ev_long, ev_col, ev_brt, skip;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

  assign long_x  = tbpc_pkg::TimeW'(long_q);
  assign min_x   = tbpc_pkg::TimeW'(min_q);
  assign lock_x  = tbpc_pkg::TimeW'(lock_q);
  assign dur     = in_q.now_ms - start_q;
  assign dt_mode = in_q.now_ms - lmode_q;
  assign dt_col  = in_q.now_ms - lcol_q;
  assign dt_brt  = in_q.now_ms - lbrt_q;
  assign brt_sum = {1'b0, brt_q} + tbpc_pkg::BrightStep;
  assign brt_mod = (brt_sum >= tbpc_pkg::BrightMod) ? brt_sum - tbpc_pkg::BrightMod : brt_sum;

  always_comb begin
    long_d  = long_q;
    min_d   = min_q;
    lock_d  = lock_q;
    smode_d = smode_q;
    shue_d  = shue_q;
    sbrt_d  = sbrt_q;
    scli_d  = scli_q;
    mode_d  = mode_q;
    hue_d   = hue_q;
    brt_d   = brt_q;
    cli_d   = cli_q;
    held_d  = held_q;
    start_d = start_q;
    lmode_d = lmode_q;
    lcol_d  = lcol_q;
    lbrt_d  = lbrt_q;
    led0_d  = led0_q;
    led1_d  = led1_q;
    led2_d  = led2_q;
    ev_short = 1'b0;
    ev_long  = 1'b0;
    ev_col   = 1'b0;
    ev_brt   = 1'b0;
    skip     = 1'b0;

    if (advance) begin
      if (in_q.mode_level) begin
        if (!held_q) begin
          held_d  = 1'b1;
          start_d = in_q.now_ms;
        end else if (dur >= long_x) begin
          cli_d   = !cli_q;
          led0_d  = in_q.now_ms + tbpc_pkg::LedLongMs;
          held_d  = 1'b0;
          ev_long = 1'b1;
          skip    = 1'b1;
        end
      end else if (held_q) begin
        if (dur < long_x && dur > min_x && dt_mode > lock_x) begin
          mode_d   = tbpc_pkg::ModeNextTab[mode_q];
          led0_d   = in_q.now_ms + tbpc_pkg::LedShortMs;
          lmode_d  = in_q.now_ms;
          ev_short = 1'b1;
        end
        held_d = 1'b0;
      end

      if (!skip) begin
        if (in_q.color_level && dt_col > lock_x) begin
          hue_d  = hue_q + tbpc_pkg::HueStep;
          led1_d = in_q.now_ms + tbpc_pkg::LedShortMs;
          lcol_d = in_q.now_ms;
          ev_col = 1'b1;
        end
        if (in_q.bright_level && dt_brt > lock_x) begin
          brt_d  = (brt_mod[tbpc_pkg::BrightW-1:0] < tbpc_pkg::BrightMin) ?
                   tbpc_pkg::BrightMin : brt_mod[tbpc_pkg::BrightW-1:0];
          led2_d = in_q.now_ms + tbpc_pkg::LedShortMs;
          lbrt_d = in_q.now_ms;
          ev_brt = 1'b1;
        end
      end
    end

    res_d.mode_value        = mode_d;
    res_d.primary_hue       = hue_d;
    res_d.secondary_hue     = hue_d + tbpc_pkg::HueHalf;
    res_d.bright_value      = brt_d;
    res_d.client_mode       = cli_d;
    res_d.short_press_event = ev_short;
    res_d.long_press_event  = ev_long;
    res_d.color_step_event  = ev_col;
    res_d.bright_step_event = ev_brt;
    res_d.mode_led_off_ms   = led0_d;
    res_d.color_led_off_ms  = led1_d;
    res_d.bright_led_off_ms = led2_d;

    if (cfg_we_i) begin
      case (tbpc_pkg::cfg_idx_e'(cfg_idx_i))
        tbpc_pkg::CfgLongPress: long_d = cfg_data_i;
        tbpc_pkg::CfgMinPress:  min_d  = cfg_data_i;
        tbpc_pkg::CfgLockout:   lock_d = cfg_data_i;
        tbpc_pkg::CfgStartMode: begin
          smode_d = cfg_data_i[tbpc_pkg::ModeW-1:0];
          mode_d  = cfg_data_i[tbpc_pkg::ModeW-1:0];
        end
        tbpc_pkg::CfgStartHue: begin
          shue_d = cfg_data_i[tbpc_pkg::HueW-1:0];
          hue_d  = cfg_data_i[tbpc_pkg::HueW-1:0];
        end
        tbpc_pkg::CfgStartBrt: begin
          sbrt_d = cfg_data_i[tbpc_pkg::BrightW-1:0];
          brt_d  = cfg_data_i[tbpc_pkg::BrightW-1:0];
        end
        tbpc_pkg::CfgStartCli: begin
          scli_d = cfg_data_i[0];
          cli_d  = cfg_data_i[0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      long_q  <= tbpc_pkg::LongPressRst;
      min_q   <= tbpc_pkg::MinPressRst;
      lock_q  <= tbpc_pkg::LockoutRst;
      smode_q <= tbpc_pkg::StartModeRst;
      shue_q  <= tbpc_pkg::StartHueRst;
      sbrt_q  <= tbpc_pkg::StartBrtRst;
      scli_q  <= tbpc_pkg::StartCliRst;
      mode_q  <= tbpc_pkg::StartModeRst;
      hue_q   <= tbpc_pkg::StartHueRst;
      brt_q   <= tbpc_pkg::StartBrtRst;
      cli_q   <= tbpc_pkg::StartCliRst;
      held_q  <= 1'b0;
      start_q <= '0;
      lmode_q <= '0;
      lcol_q  <= '0;
      lbrt_q  <= '0;
      led0_q  <= '0;
      led1_q  <= '0;
      led2_q  <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      long_q  <= long_d;
      min_q   <= min_d;
      lock_q  <= lock_d;
      smode_q <= smode_d;
      shue_q  <= shue_d;
      sbrt_q  <= sbrt_d;
      scli_q  <= scli_d;
      mode_q  <= mode_d;
      hue_q   <= hue_d;
      brt_q   <= brt_d;
      cli_q   <= cli_d;
      held_q  <= held_d;
      start_q <= start_d;
      lmode_q <= lmode_d;
      lcol_q  <= lcol_d;
      lbrt_q  <= lbrt_d;
      led0_q  <= led0_d;
      led1_q  <= led1_d;
      led2_q  <= led2_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // a long press skips the other buttons and never coincides with a short press
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.long_press_event |->
      !res_q.short_press_event && !res_q.color_step_event && !res_q.bright_step_event)
    else $error("long press event alongside another event");

  // a processed item always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item lost");

  // a stalled result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(res_q))
    else $error("stalled result changed");

  // apart from a config write, the client flag only moves on a long press
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !cfg_we_i && (cli_d != cli_q) |-> ev_long)
    else $error("client flag changed without long press");

endmodule
